// ===== sv/softmax_normalizer_defines.svh =====
// ----------------------------------------------------------------------------
// softmax_normalizer_defines.svh
// Assertion macros used by the sm_chk port checks of the softmax normalizer.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_NORMALIZER_DEFINES_SVH
`define SOFTMAX_NORMALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sm_pkg.sv =====
// ----------------------------------------------------------------------------
// sm_pkg
// Widths, constants and the 2^(-f/N) table of the softmax normalizer.
// ----------------------------------------------------------------------------
package sm_pkg;

    localparam int SCORE_W        = 16;
    localparam int PROB_W         = 16;
    localparam int EXP_W          = 16;
    localparam int SUM_W          = 23;
    localparam int MAX_LEN_DEF    = 64;

    // exp table, power of two entries
    localparam int EXP_TABLE_SIZE = 256;
    localparam int LOG2N          = $clog2(EXP_TABLE_SIZE);

    // log2(e) in Q16, ln2 in Q32
    localparam int            LOG2E_W   = 17;
    localparam logic [16:0]   LOG2E_Q16 = 17'd94548;
    localparam longint unsigned LN2_Q32 = 64'd2977044472;

    // d * log2(e) * N / 2^24, rounded
    localparam int PROD_W    = SCORE_W + LOG2E_W;
    localparam int EXP_SHIFT = 24 - LOG2N;
    localparam int Y_W       = PROD_W + 1 - EXP_SHIFT;
    localparam int INT_W     = Y_W - LOG2N;
    localparam int EXP_ZERO_SHIFT = 16;

    // divider: quotient bits and bits retired per cycle
    localparam int DIV_Q_W    = 18;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_CYCLES = DIV_Q_W / DIV_STEPS;

    typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

    // floor(x / k) for a small k, shift and subtract
    function automatic longint unsigned div_small(longint unsigned x, longint unsigned k);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((x >> b) & 64'd1);
            q = q << 1;
            if (r >= k)
            begin
                r = r - k;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // 2^(-f/N) in Q0.16 via 14-term Taylor series of exp(-f*ln2/N), saturated
    function automatic exp_tab_t exp_table_build();
        exp_tab_t           tab;
        longint unsigned    a;
        longint unsigned    term;
        longint             acc;
        longint unsigned    r;
        for (int f = 0; f < EXP_TABLE_SIZE; f++)
        begin
            a    = (longint'(f) * LN2_Q32) >> LOG2N;
            term = 64'd1 << 32;
            acc  = longint'(term);
            for (int k = 1; k <= 13; k++)
            begin
                term = div_small((term * a) >> 32, 64'(k));
                if ((k & 1) == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            r = (longint'(acc) + 64'd32768) >> 16;
            tab[f] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = exp_table_build();

endpackage

// ===== sv/sm_score_if.sv =====
// ----------------------------------------------------------------------------
// sm_score_if
// Valid/ready channel carrying one score beat.
// ----------------------------------------------------------------------------
interface sm_score_if
    import sm_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               last_score;

    modport source (output valid, output score, output last_score, input ready);
    modport sink   (input valid, input score, input last_score, output ready);
endinterface

// ===== sv/sm_prob_if.sv =====
// ----------------------------------------------------------------------------
// sm_prob_if
// Valid/ready channel carrying one probability beat.
// ----------------------------------------------------------------------------
interface sm_prob_if
    import sm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [PROB_W-1:0] probability;
    logic              last_prob;

    modport source (output valid, output probability, output last_prob, input ready);
    modport sink   (input valid, input probability, input last_prob, output ready);
endinterface

// ===== sv/sm_ram.sv =====
// ----------------------------------------------------------------------------
// sm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sm_exp.sv =====
// ----------------------------------------------------------------------------
// sm_exp
// Two-stage exp unit: gap times log2(e), then table lookup and shift.
// ----------------------------------------------------------------------------
module sm_exp
    import sm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [SCORE_W-1:0]        score,
    input  logic signed [SCORE_W-1:0] max_score,
    output logic                      out_valid,
    output logic [EXP_W-1:0]          exp_val
);

    localparam logic [PROD_W:0] ROUND = (PROD_W+1)'(1) << (EXP_SHIFT - 1);

    logic signed [SCORE_W:0] gap;
    logic [PROD_W-1:0]       prod_reg;
    logic                    valid_a_reg;
    logic [PROD_W:0]         rounded;
    logic [Y_W-1:0]          y;
    logic [INT_W-1:0]        int_part;
    logic [LOG2N-1:0]        frac_idx;
    logic [EXP_W-1:0]        exp_next;
    logic [EXP_W-1:0]        exp_reg;
    logic                    valid_b_reg;

    // max >= every stored score, so the gap fits 16 bits unsigned
    assign gap = {max_score[SCORE_W-1], max_score} - {score[SCORE_W-1], score};

    always_ff @(posedge clk)
    begin
        prod_reg <= gap[SCORE_W-1:0] * LOG2E_Q16;
        exp_reg  <= exp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_comb
    begin
        rounded  = {1'b0, prod_reg} + ROUND;
        y        = rounded[PROD_W:EXP_SHIFT];
        int_part = y[Y_W-1:LOG2N];
        frac_idx = y[LOG2N-1:0];
        if (int_part > INT_W'(EXP_ZERO_SHIFT))
            exp_next = '0;
        else
            exp_next = EXP_TABLE[frac_idx] >> int_part[4:0];
    end

    assign out_valid = valid_b_reg;
    assign exp_val   = exp_reg;

endmodule

// ===== sv/sm_div.sv =====
// ----------------------------------------------------------------------------
// sm_div
// Restoring divider for (e << 16) / sum, three quotient bits per cycle.
// ----------------------------------------------------------------------------
module sm_div
    import sm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [EXP_W-1:0]  dividend,
    input  logic [SUM_W-1:0]  divisor,
    output logic              busy,
    output logic [PROB_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_CYCLES + 1);

    logic [SUM_W-1:0]   rem_reg,  rem_next;
    logic [DIV_Q_W-1:0] dvd_reg,  dvd_next;
    logic [DIV_Q_W-1:0] q_reg,    q_next;
    logic [SUM_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic [SUM_W:0]     shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = '0;
        if (start)
        begin
            // top quotient bits are zero since e[15:2] < sum
            rem_next  = SUM_W'(dividend[EXP_W-1:2]);
            dvd_next  = {dividend[1:0], 16'b0};
            q_next    = '0;
            cnt_next  = CNT_W'(DIV_CYCLES);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                shifted  = {rem_next, dvd_next[DIV_Q_W-1]};
                dvd_next = {dvd_next[DIV_Q_W-2:0], 1'b0};
                if (shifted >= {1'b0, dsr_reg})
                begin
                    shifted = shifted - {1'b0, dsr_reg};
                    q_next  = {q_next[DIV_Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next  = {q_next[DIV_Q_W-2:0], 1'b0};
                end
                rem_next = shifted[SUM_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        if (start)
            dsr_reg <= divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = (q_reg > DIV_Q_W'(16'hFFFF)) ? 16'hFFFF : q_reg[PROB_W-1:0];

endmodule

// ===== sv/softmax_normalizer.sv =====
// ----------------------------------------------------------------------------
// softmax_normalizer
// Fixed-point softmax over a vector of up to MAX_LEN Q7.8 scores.
// ----------------------------------------------------------------------------
// Scores stream in one beat per cycle and are written to a score RAM while
// the running maximum is tracked; the beat with last_score set closes the
// vector. Then an exp pass reads each stored score (one read per cycle),
// forms 2^(-(max-s)*log2 e) through a 256-entry table and a shift, writes it
// to an exp RAM and adds it to the sum. A divide pass follows: per element
// one exp RAM read, a divider run and a load of the output register, the
// load waiting while the receiver stalls the output beat. The divider sets
// the rate. Scores are not taken during the exp and divide passes; the next
// vector may start as soon as the last probability sits in the output
// register. Beats beyond MAX_LEN are dropped but a last marker on them still
// closes the vector. Both RAMs need no clearing after reset.
// ----------------------------------------------------------------------------
module softmax_normalizer
    import sm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sm_score_if.sink     scores,
    sm_prob_if.source    probs
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [4:0] {
        S_LOAD      = 5'b00001,
        S_EXP       = 5'b00010,
        S_DIV_RD    = 5'b00100,
        S_DIV_START = 5'b01000,
        S_DIV_RUN   = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SCORE_W-1:0] max_reg,   max_next;
    logic [SUM_W-1:0]          sum_reg,   sum_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic [CNT_W-1:0]          done_reg,  done_next;
    logic [CNT_W-1:0]          idx_reg,   idx_next;
    logic                      rd_pend_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [PROB_W-1:0]         prob_reg;
    logic                      last_reg;

    logic                      in_beat;
    logic                      store_en;
    logic                      score_rd_en;
    logic [SCORE_W-1:0]        score_rd_data;
    logic                      exp_valid;
    logic [EXP_W-1:0]          exp_val;
    logic                      exp_rd_en;
    logic [EXP_W-1:0]          exp_rd_data;
    logic                      div_start;
    logic                      div_busy;
    logic [PROB_W-1:0]         div_q;
    logic                      out_load;
    logic                      out_last;

    assign scores.ready = (state_reg == S_LOAD);
    assign in_beat      = scores.valid && scores.ready;
    assign store_en     = in_beat && (count_reg < CNT_W'(MAX_LEN));

    // exp pass read issue, one score per cycle
    assign score_rd_en  = (state_reg == S_EXP) && (issue_reg < count_reg);
    assign exp_rd_en    = (state_reg == S_DIV_RD);
    assign div_start    = (state_reg == S_DIV_START);
    assign out_last     = ((idx_reg + 1'b1) == count_reg);
    assign out_load     = (state_reg == S_DIV_RUN) && !div_busy
                          && (!out_valid_reg || probs.ready);

    sm_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_LEN)
    ) u_score_ram (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (scores.score),
        .rd_en   (score_rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (score_rd_data)
    );

    sm_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_pend_reg),
        .score     (score_rd_data),
        .max_score (max_reg),
        .out_valid (exp_valid),
        .exp_val   (exp_val)
    );

    // results return in issue order, so done_reg is the write address
    sm_ram #(
        .WIDTH (EXP_W),
        .DEPTH (MAX_LEN)
    ) u_exp_ram (
        .clk     (clk),
        .wr_en   (exp_valid),
        .wr_addr (done_reg[IDX_W-1:0]),
        .wr_data (exp_val),
        .rd_en   (exp_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (exp_rd_data)
    );

    sm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (exp_rd_data),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        issue_next = issue_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (store_en)
                begin
                    count_next = count_reg + 1'b1;
                    if ($signed(scores.score) > max_reg)
                        max_next = $signed(scores.score);
                end
                if (in_beat && scores.last_score)
                    state_next = S_EXP;
            end
            S_EXP:
            begin
                if (score_rd_en)
                    issue_next = issue_reg + 1'b1;
                if (exp_valid)
                begin
                    done_next = done_reg + 1'b1;
                    sum_next  = sum_reg + SUM_W'(exp_val);
                end
                if (done_reg == count_reg)
                    state_next = S_DIV_RD;
            end
            S_DIV_RD:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (out_load)
                begin
                    if (out_last)
                    begin
                        // vector done, back to the reset state
                        state_next = S_LOAD;
                        count_next = '0;
                        max_next   = {1'b1, {(SCORE_W-1){1'b0}}};
                        sum_next   = '0;
                        issue_next = '0;
                        done_next  = '0;
                        idx_next   = '0;
                    end
                    else
                    begin
                        state_next = S_DIV_RD;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (probs.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            max_reg       <= {1'b1, {(SCORE_W-1){1'b0}}};
            sum_reg       <= '0;
            issue_reg     <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            issue_reg     <= issue_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= score_rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            prob_reg <= div_q;
            last_reg <= out_last;
        end
    end

    assign probs.valid       = out_valid_reg;
    assign probs.probability = prob_reg;
    assign probs.last_prob   = last_reg;

endmodule

// ===== sv/sm_chk.sv =====
// ----------------------------------------------------------------------------
// sm_chk
// Port-level checks of the softmax normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "softmax_normalizer_defines.svh"

module sm_chk
    import sm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              last_score,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [PROB_W-1:0] probability,
    input  logic              last_prob
);

    // a stalled beat holds
    `SM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(probability) && $stable(last_prob), "output beat changed under stall")

    // closing beat stops intake
    `SM_ASSERT_NEXT(a_close_stops, in_valid && in_ready && last_score, !in_ready, "score taken after closing beat")

    // intake stays open until a closing beat
    `SM_ASSERT_NEXT(a_load_holds, in_ready && !(in_valid && last_score), in_ready, "intake closed without closing beat")

    // no intake while a vector is still being emitted
    `SM_ASSERT_NOW(a_emit_blocks, out_valid && !last_prob, !in_ready, "intake open mid-vector")

endmodule

bind softmax_normalizer sm_chk u_sm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (scores.valid),
    .in_ready    (scores.ready),
    .last_score  (scores.last_score),
    .out_valid   (probs.valid),
    .out_ready   (probs.ready),
    .probability (probs.probability),
    .last_prob   (probs.last_prob)
);

// ===== tb/softmax_normalizer_checker.sv =====
// ----------------------------------------------------------------------------
// softmax_normalizer_checker
// Watches the score and probability channels, predicts each probability
// beat and compares it with what the block puts out.
// ----------------------------------------------------------------------------
module softmax_normalizer_checker
    import sm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sm_score_if.sink    scores,
    sm_prob_if.sink     probs,
    output int          fail_count,
    output int          pending_probs
);

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              last_prob;
    } prob_beat_t;

    localparam int VEC_MAX = MAX_LEN_DEF;

    logic [SCORE_W-1:0] vec_scores [VEC_MAX];
    int                 vec_len;
    int                 vec_max;
    prob_beat_t         prob_queue [$];
    logic [EXP_W-1:0]   pow2_frac [EXP_TABLE_SIZE];

    // 2^(-f/N) in Q0.16, series evaluation of exp(-f*ln2/N)
    function automatic logic [EXP_W-1:0] frac_pow2(int f);
        longint unsigned a;
        longint unsigned term;
        longint          acc;
        longint unsigned r;
        a    = (longint'(f) * 64'd2977044472) / EXP_TABLE_SIZE;
        term = 64'd1 << 32;
        acc  = longint'(term);
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * a) >> 32) / longint'(k);
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = (unsigned'(acc) + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [EXP_W-1:0] exp_of_gap(longint unsigned d);
        longint unsigned y;
        longint unsigned ip;
        y  = (d * 64'd94548 * EXP_TABLE_SIZE + (64'd1 << 23)) >> 24;
        ip = y / EXP_TABLE_SIZE;
        if (ip > 16)
            return '0;
        return pow2_frac[y % EXP_TABLE_SIZE] >> ip;
    endfunction

    // close the vector: queue one probability per stored score
    task automatic normalize_vector();
        logic [EXP_W-1:0] ex [VEC_MAX];
        logic [SUM_W-1:0] total;
        longint unsigned  p;
        prob_beat_t       b;
        total = '0;
        for (int i = 0; i < vec_len; i++)
        begin
            ex[i] = exp_of_gap(longint'(vec_max - int'($signed(vec_scores[i]))));
            total = total + ex[i];
        end
        for (int i = 0; i < vec_len; i++)
        begin
            p = 0;
            if (total != 0)
            begin
                p = (64'(ex[i]) << 16) / total;
                if (p > 65535)
                    p = 65535;
            end
            b.probability = p[15:0];
            b.last_prob   = (i + 1 == vec_len);
            prob_queue.push_back(b);
        end
        vec_len = 0;
        vec_max = -32768;
    endtask

    initial
    begin
        for (int f = 0; f < EXP_TABLE_SIZE; f++)
            pow2_frac[f] = frac_pow2(f);
    end

    always @(posedge clk)
    begin
        prob_beat_t want;
        if (!rst_n)
        begin
            vec_len    = 0;
            vec_max    = -32768;
            fail_count = 0;
            prob_queue.delete();
        end
        if (rst_n && probs.valid && probs.ready)
        begin
            if (prob_queue.size() == 0)
            begin
                $error("unexpected probability beat %0d", probs.probability);
                fail_count++;
            end
            else
            begin
                want = prob_queue.pop_front();
                if (probs.probability !== want.probability)
                begin
                    $error("probability: expected %0d, got %0d",
                           want.probability, probs.probability);
                    fail_count++;
                end
                if (probs.last_prob !== want.last_prob)
                begin
                    $error("last_prob: expected %0d, got %0d",
                           want.last_prob, probs.last_prob);
                    fail_count++;
                end
            end
        end
        if (rst_n && scores.valid && scores.ready)
        begin
            if (vec_len < VEC_MAX)
            begin
                vec_scores[vec_len] = scores.score;
                vec_len++;
                if (int'($signed(scores.score)) > vec_max)
                    vec_max = int'($signed(scores.score));
            end
            if (scores.last_score)
                normalize_vector();
        end
        pending_probs <= prob_queue.size();
    end

endmodule

// ===== tb/softmax_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// softmax_normalizer_test
// Drives score vectors into the softmax normalizer with random gaps and
// back-pressure; the checker predicts and compares every probability beat.
// ----------------------------------------------------------------------------
module softmax_normalizer_test
    import sm_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_probs;
    int   cycle_count = 0;
    bit   quiet_phase;     // no idling on either side
    bit   sink_hold;       // long receiver stall

    sm_score_if scores ();
    sm_prob_if  probs ();

    softmax_normalizer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .scores (scores.sink),
        .probs  (probs.source)
    );

    softmax_normalizer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .scores        (scores.sink),
        .probs         (probs.sink),
        .fail_count    (fail_count),
        .pending_probs (pending_probs)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, a long hold on request, none in the quiet phase
    always @(posedge clk)
    begin
        if (sink_hold)
            probs.ready <= 1'b0;
        else if (quiet_phase)
            probs.ready <= 1'b1;
        else
            probs.ready <= ($urandom_range(99) >= 23);
    end

    // offer one beat, idling at random first; hold until accepted
    task automatic send_score(logic [SCORE_W-1:0] s, logic last);
        while (!quiet_phase && $urandom_range(99) < 23)
        begin
            scores.valid <= 1'b0;
            @(posedge clk);
        end
        scores.valid      <= 1'b1;
        scores.score      <= s;
        scores.last_score <= last;
        @(posedge clk);
        while (!scores.ready)
            @(posedge clk);
    endtask

    task automatic send_vector(int len, int lo, int hi);
        for (int i = 0; i < len; i++)
            send_score(16'($urandom_range(hi - lo) + lo), i == len - 1);
    endtask

    task automatic wait_drained();
        scores.valid <= 1'b0;
        @(posedge clk);
        while (pending_probs != 0)
            @(posedge clk);
    endtask

    int sent;
    int len;
    int spread;

    initial
    begin
        quiet_phase       = 1'b0;
        sink_hold         = 1'b0;
        rst_n             = 1'b0;
        scores.valid      = 1'b0;
        scores.score      = '0;
        scores.last_score = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single element, extremes, ties, huge gap
        send_score(16'h7FFF, 1'b1);
        send_score(16'h8000, 1'b1);
        send_score(16'h8000, 1'b0);
        send_score(16'h7FFF, 1'b1);
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b1);
        send_score(16'h0100, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'hFF00, 1'b0);
        send_score(16'hFFFF, 1'b0);
        send_score(16'h5555, 1'b0);
        send_score(16'hAAAA, 1'b1);
        wait_drained();

        // overlong vector, closed by a dropped beat; receiver held off meanwhile,
        // and a second vector offered while the block is stalled
        sink_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 70; i++)
            send_score(16'($urandom_range(2047) - 1024), i == 69);
        send_vector(4, -512, 512);
        sent = 87;
        wait_drained();

        // random vectors, mostly short with close scores
        while (sent < 450)
        begin
            quiet_phase = (sent > 250 && sent < 300);
            case ($urandom_range(9))
                0:       len = $urandom_range(64, 40);
                1:       len = 1;
                default: len = $urandom_range(8, 2);
            endcase
            spread = ($urandom_range(3) == 0) ? 65535 : $urandom_range(3000, 16);
            if (spread == 65535)
                send_vector(len, 0, 65535);
            else
                send_vector(len, -(spread / 2), spread / 2);
            sent += len;
        end
        quiet_phase = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
